// ===== hw/rtl/ipow_pkg.sv =====
// ipow_pkg: shared constants for the integer power pipeline
// no dependencies
`default_nettype none
package ipow_pkg;
    localparam int FIELD_W = 32;
    localparam int COUNT_W = 6;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;
endpackage
`default_nettype wire

// ===== hw/rtl/ipow_stage.sv =====
// ipow_stage: one exponent bit of left-to-right square-and-multiply
// depends on ipow_pkg
`default_nettype none
module ipow_stage #(
    parameter int WIDTH = 32,
    parameter int EXP_BITS = 32,
    parameter int CNT_W = 7
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                in_started,
    input  wire logic [WIDTH-1:0]    in_acc,
    input  wire logic [WIDTH-1:0]    in_base,
    input  wire logic [EXP_BITS-1:0] in_exp,
    input  wire logic [CNT_W-1:0]    in_count,
    input  wire logic                bit_value,
    output logic                     out_valid,
    output logic                     out_started,
    output logic [WIDTH-1:0]         out_acc,
    output logic [WIDTH-1:0]         out_base,
    output logic [EXP_BITS-1:0]      out_exp,
    output logic [CNT_W-1:0]         out_count
);
    import ipow_pkg::*;

    // two half steps: square registered, then optional multiply by base
    logic                valid_reg, started_reg, bit_reg;
    logic [WIDTH-1:0]    sq_reg, sq_next, base_reg, acc_reg;
    logic [EXP_BITS-1:0] exp_reg;
    logic [CNT_W-1:0]    count_reg;

    logic [2*WIDTH-1:0]  sq_full, mul_full;

    assign sq_full = in_acc * in_acc;
    // before the top set bit the accumulator is seeded with the base
    assign sq_next = in_started ? sq_full[WIDTH-1:0] : in_base;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
            out_valid <= valid_reg;
        end
    end

    assign mul_full = sq_reg * base_reg;

    always_ff @(posedge clk)
    begin
        sq_reg      <= sq_next;
        base_reg    <= in_base;
        exp_reg     <= in_exp;
        bit_reg     <= bit_value;
        started_reg <= in_started;
        if (in_started)
            count_reg <= in_count + CNT_W'(1) + CNT_W'(bit_value);
        else
            count_reg <= in_count;
        if (started_reg && bit_reg)
            acc_reg <= mul_full[WIDTH-1:0];
        else
            acc_reg <= sq_reg;
        out_started <= started_reg | bit_reg;
        out_base    <= base_reg;
        out_exp     <= exp_reg;
        out_count   <= count_reg;
    end

    assign out_acc = acc_reg;

    property p_count_grows;
        @(posedge clk) disable iff (!rst_n)
            valid_reg |=> (out_count >= $past(in_count, 2));
    endproperty
    a_count_grows: assert property (p_count_grows) else $error("count shrank");

    property p_unstarted_acc;
        @(posedge clk) disable iff (!rst_n)
            (valid_reg && !started_reg) |=> (out_acc == $past(base_reg));
    endproperty
    a_unstarted_acc: assert property (p_unstarted_acc) else $error("seed lost");

    property p_valid_delay;
        @(posedge clk) disable iff (!rst_n)
            in_valid |=> ##1 out_valid;
    endproperty
    a_valid_delay: assert property (p_valid_delay) else $error("valid lost");
endmodule
`default_nettype wire

// ===== hw/rtl/integer_power_by_squaring.sv =====
// integer_power_by_squaring: top level, chain of per-bit stages
// depends on ipow_pkg and ipow_stage
`default_nettype none
// Computes base**exponent mod 2**WIDTH and the square-and-multiply count.
// One item may start every cycle (busy is always low). The result appears
// on power/mult_count with done high once the item has passed every stage
// and the output registers; the receiver takes it while done is high. The
// pipeline is one two-register stage per exponent bit, each holding one
// squarer and one multiplier. The receiver cannot stall; done lasts one cycle.
module integer_power_by_squaring #(
    parameter int WIDTH = 32,
    parameter int EXP_BITS = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [ipow_pkg::FIELD_W-1:0]   base,
    input  wire logic [ipow_pkg::FIELD_W-1:0]   exponent,
    output logic                                done,
    output logic [ipow_pkg::FIELD_W-1:0]        power,
    output logic [ipow_pkg::COUNT_W-1:0]        mult_count
);
    import ipow_pkg::*;

    localparam int CNT_W = $clog2(2*EXP_BITS + 1) + 1;

    logic                v   [EXP_BITS+1];
    logic                st  [EXP_BITS+1];
    logic [WIDTH-1:0]    acc [EXP_BITS+1];
    logic [WIDTH-1:0]    bs  [EXP_BITS+1];
    logic [EXP_BITS-1:0] ex  [EXP_BITS+1];
    logic [CNT_W-1:0]    cn  [EXP_BITS+1];

    logic [FIELD_W+EXP_BITS-1:0] exp_wide;
    logic [FIELD_W+WIDTH-1:0]    base_wide;
    logic                        done_reg, started_last;
    logic [WIDTH-1:0]            acc_last;
    logic [CNT_W-1:0]            cnt_last;
    logic [FIELD_W-1:0]          power_reg;
    logic [COUNT_W-1:0]          count_reg;

    assign busy      = 1'b0;
    assign exp_wide  = {{EXP_BITS{1'b0}}, exponent};
    assign base_wide = {{WIDTH{1'b0}}, base};

    assign v[0]   = start;
    assign st[0]  = 1'b0;
    assign acc[0] = '0;
    assign bs[0]  = base_wide[WIDTH-1:0];
    assign ex[0]  = exp_wide[EXP_BITS-1:0];
    assign cn[0]  = '0;

    // stage k handles exponent bit EXP_BITS-1-k, high to low
    for (genvar k = 0; k < EXP_BITS; k++)
    begin : g_stage
        ipow_stage #(.WIDTH(WIDTH), .EXP_BITS(EXP_BITS), .CNT_W(CNT_W)) u_stage (
            .clk(clk), .rst_n(rst_n),
            .in_valid(v[k]), .in_started(st[k]), .in_acc(acc[k]),
            .in_base(bs[k]), .in_exp(ex[k]), .in_count(cn[k]),
            .bit_value(ex[k][EXP_BITS-1-k]),
            .out_valid(v[k+1]), .out_started(st[k+1]), .out_acc(acc[k+1]),
            .out_base(bs[k+1]), .out_exp(ex[k+1]), .out_count(cn[k+1])
        );
    end

    assign started_last = st[EXP_BITS];
    assign acc_last     = started_last ? acc[EXP_BITS] : {{(WIDTH-1){1'b0}}, 1'b1};
    // the top set bit only seeds the accumulator, so it adds nothing to the count
    assign cnt_last     = started_last ? cn[EXP_BITS] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= v[EXP_BITS];
    end

    always_ff @(posedge clk)
    begin
        power_reg <= FIELD_W'({{FIELD_W{1'b0}}, acc_last});
        if (cnt_last > CNT_W'(COUNT_MAX))
            count_reg <= COUNT_MAX;
        else
            count_reg <= cnt_last[COUNT_W-1:0];
    end

    assign done       = done_reg;
    assign power      = power_reg;
    assign mult_count = count_reg;

    property p_zero_exp;
        @(posedge clk) disable iff (!rst_n)
            (v[EXP_BITS] && !started_last) |=> (power == FIELD_W'(1) && mult_count == '0);
    endproperty
    a_zero_exp: assert property (p_zero_exp) else $error("zero exponent result");

    property p_never_busy;
        @(posedge clk) disable iff (!rst_n) !busy;
    endproperty
    a_never_busy: assert property (p_never_busy) else $error("busy raised");

    property p_done_follows;
        @(posedge clk) disable iff (!rst_n) v[EXP_BITS] |=> done;
    endproperty
    a_done_follows: assert property (p_done_follows) else $error("result dropped");
endmodule
`default_nettype wire
